FILE: hdl/uf2v_pkg.sv
`default_nettype none
package uf2v_pkg;

	localparam int unsigned CNT_W = 14;
	localparam int unsigned POS_W = 10;
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW = 2;

	localparam logic [31:0] MAGIC_A = 32'h0A32_4655;
	localparam logic [31:0] MAGIC_B = 32'h9E5D_5157;
	localparam logic [31:0] MAGIC_END = 32'h0AB1_6F30;
	localparam logic [31:0] FLAG_FAMILY = 32'h0000_2000;
	localparam logic [31:0] FAM_SINGLE = 32'hE48B_FF56;
	localparam logic [31:0] FAM_ALT0 = 32'hE48B_FF59;
	localparam logic [31:0] FAM_ALT1 = 32'hE48B_FF5A;
	localparam logic [31:0] FAM_ALT2 = 32'hE48B_FF5B;
	localparam logic [31:0] PAYLOAD_MAX = 32'd476;

	localparam logic [POS_W-1:0] POS_BLOCK_END = 10'd511;
	localparam logic [POS_W-1:0] POS_SAT = 10'd1023;
	localparam logic [POS_W-1:0] POS_MAGIC_A = 10'd3;
	localparam logic [POS_W-1:0] POS_MAGIC_B = 10'd7;
	localparam logic [POS_W-1:0] POS_FLAGS = 10'd11;
	localparam logic [POS_W-1:0] POS_PAYLOAD = 10'd19;
	localparam logic [POS_W-1:0] POS_INDEX = 10'd23;
	localparam logic [POS_W-1:0] POS_TOTAL = 10'd27;
	localparam logic [POS_W-1:0] POS_FAMILY = 10'd31;

	localparam logic [CNT_W-1:0] CNT_SAT = 14'd16383;

	localparam logic [1:0] CFG_BLOCK_COUNT = 2'd0;
	localparam logic [1:0] CFG_TARGET_CHIP = 2'd1;

	localparam logic KIND_BLOCK = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	typedef enum logic [2:0] {
		ST_OK,
		ST_BAD_MAGIC,
		ST_BAD_BLOCK,
		ST_DUPLICATE,
		ST_WRONG_FAMILY,
		ST_NO_FAMILY,
		ST_INCOMPLETE
	} status_t;

	typedef struct packed {
		logic             kind;
		logic             len_bad;
		logic             pay_big;
		logic             decl_big;
		logic [CNT_W-1:0] decl_lo;
		logic             idx_big;
		logic [CNT_W-1:0] idx_lo;
		logic             fam_flag;
		logic [31:0]      fam;
	} job_t;

endpackage
`default_nettype wire

FILE: hdl/uf2_block_stream_validator_top.sv
// A block-end byte or finish query shows its verdict on out_valid after passing through the job
// FIFO, the back-end read stage and the output register; other data bytes produce no verdict.
// Throughput: one item per cycle while the job FIFO is not full, set by the pipelined bitmap access.
// Reset: asynchronous and active low; afterwards the seen bitmap is cleared one entry per
// cycle from entry 0 up to MAX_BLOCKS-1, during which in_ready stays low.
`default_nettype none
module uf2_block_stream_validator_top #(
	parameter int unsigned MAX_BLOCKS = 8192
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [uf2v_pkg::CNT_W-1:0] cfg_wdata,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       command,
	input  wire logic [7:0]                 data_byte,
	input  wire logic                       last_byte,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [2:0]                      status,
	output logic                            verdict_kind,
	output logic [31:0]                     family_word,
	output logic [uf2v_pkg::CNT_W-1:0]      blocks_counted
);

	logic [uf2v_pkg::CNT_W-1:0] block_count_q;
	logic                       target_chip_q;

	logic                       push;
	uf2v_pkg::job_t             push_job;
	uf2v_pkg::job_t             head_job;
	logic                       empty;
	logic                       full;
	logic                       pop;
	logic                       clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= '0;
			target_chip_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				uf2v_pkg::CFG_BLOCK_COUNT: begin
					block_count_q <= cfg_wdata;
				end
				uf2v_pkg::CFG_TARGET_CHIP: begin
					target_chip_q <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	uf2v_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.clearing  (clearing),
		.full      (full),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.push      (push),
		.push_job  (push_job)
	);

	uf2v_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.empty    (empty),
		.full     (full)
	);

	uf2v_back #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_job       (head_job),
		.empty          (empty),
		.pop            (pop),
		.clearing       (clearing),
		.block_count    (block_count_q),
		.target_chip    (target_chip_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.verdict_kind   (verdict_kind),
		.family_word    (family_word),
		.blocks_counted (blocks_counted)
	);

endmodule
`default_nettype wire

FILE: hdl/uf2v_front.sv
`default_nettype none
module uf2v_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              clearing,
	input  wire logic              full,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              command,
	input  wire logic [7:0]        data_byte,
	input  wire logic              last_byte,
	output logic                   push,
	output uf2v_pkg::job_t         push_job
);

	logic [uf2v_pkg::POS_W-1:0] pos_q;
	logic [31:0]                wa_q;
	logic                       magic_good_q;
	logic                       fam_flag_q;
	logic                       pay_big_q;
	logic                       decl_big_q;
	logic [uf2v_pkg::CNT_W-1:0] decl_lo_q;
	logic                       idx_big_q;
	logic [uf2v_pkg::CNT_W-1:0] idx_lo_q;
	logic [31:0]                fam_q;

	logic                       accept;
	logic                       in_block;
	logic                       word_done;
	logic [31:0]                wa_nx;
	logic                       magic_nx;

	assign in_ready = !full && !clearing;
	assign accept = in_valid && in_ready;
	assign in_block = !pos_q[uf2v_pkg::POS_W-1];
	assign wa_nx = {data_byte, wa_q[31:8]};
	assign word_done = in_block && (pos_q[1:0] == 2'b11);

	always_comb begin
		magic_nx = magic_good_q;
		if (word_done) begin
			if (pos_q == uf2v_pkg::POS_MAGIC_A && wa_nx != uf2v_pkg::MAGIC_A) begin
				magic_nx = 1'b0;
			end
			if (pos_q == uf2v_pkg::POS_MAGIC_B && wa_nx != uf2v_pkg::MAGIC_B) begin
				magic_nx = 1'b0;
			end
			if (pos_q == uf2v_pkg::POS_BLOCK_END && wa_nx != uf2v_pkg::MAGIC_END) begin
				magic_nx = 1'b0;
			end
		end
	end

	assign push = accept && (command || last_byte);

	always_comb begin
		push_job.kind = command ? uf2v_pkg::KIND_FINISH : uf2v_pkg::KIND_BLOCK;
		push_job.len_bad = (pos_q != uf2v_pkg::POS_BLOCK_END) || !magic_nx;
		push_job.pay_big = pay_big_q;
		push_job.decl_big = decl_big_q;
		push_job.decl_lo = decl_lo_q;
		push_job.idx_big = idx_big_q;
		push_job.idx_lo = idx_lo_q;
		push_job.fam_flag = fam_flag_q;
		push_job.fam = fam_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			wa_q <= '0;
			magic_good_q <= 1'b1;
			fam_flag_q <= 1'b0;
			pay_big_q <= 1'b0;
			decl_big_q <= 1'b0;
			decl_lo_q <= '0;
			idx_big_q <= 1'b0;
			idx_lo_q <= '0;
			fam_q <= '0;
		end else if (accept && !command) begin
			if (last_byte) begin
				pos_q <= '0;
				wa_q <= '0;
				magic_good_q <= 1'b1;
				fam_flag_q <= 1'b0;
				pay_big_q <= 1'b0;
				decl_big_q <= 1'b0;
				decl_lo_q <= '0;
				idx_big_q <= 1'b0;
				idx_lo_q <= '0;
				fam_q <= '0;
			end else begin
				if (pos_q != uf2v_pkg::POS_SAT) begin
					pos_q <= pos_q + 1'b1;
				end
				if (in_block) begin
					wa_q <= wa_nx;
				end
				magic_good_q <= magic_nx;
				if (word_done) begin
					case (pos_q)
						uf2v_pkg::POS_FLAGS: begin
							fam_flag_q <= (wa_nx & uf2v_pkg::FLAG_FAMILY) != '0;
						end
						uf2v_pkg::POS_PAYLOAD: begin
							pay_big_q <= wa_nx > uf2v_pkg::PAYLOAD_MAX;
						end
						uf2v_pkg::POS_INDEX: begin
							idx_big_q <= wa_nx[31:uf2v_pkg::CNT_W] != '0;
							idx_lo_q <= wa_nx[uf2v_pkg::CNT_W-1:0];
						end
						uf2v_pkg::POS_TOTAL: begin
							decl_big_q <= wa_nx[31:uf2v_pkg::CNT_W] != '0;
							decl_lo_q <= wa_nx[uf2v_pkg::CNT_W-1:0];
						end
						uf2v_pkg::POS_FAMILY: begin
							fam_q <= wa_nx;
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: hdl/uf2v_fifo.sv
`default_nettype none
module uf2v_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  uf2v_pkg::job_t      push_job,
	input  wire logic           pop,
	output uf2v_pkg::job_t      head_job,
	output logic                empty,
	output logic                full
);

	uf2v_pkg::job_t           ent_q [uf2v_pkg::QDEPTH];
	logic [uf2v_pkg::QAW-1:0] wr_q;
	logic [uf2v_pkg::QAW-1:0] rd_q;
	logic [uf2v_pkg::QAW:0]   cnt_q;

	assign empty = cnt_q == '0;
	assign full = cnt_q == (uf2v_pkg::QAW+1)'(uf2v_pkg::QDEPTH);
	assign head_job = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hdl/uf2v_back.sv
`default_nettype none
module uf2v_back #(
	parameter int unsigned MAX_BLOCKS = 8192
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  uf2v_pkg::job_t                  head_job,
	input  wire logic                       empty,
	output logic                            pop,
	output logic                            clearing,
	input  wire logic [uf2v_pkg::CNT_W-1:0] block_count,
	input  wire logic                       target_chip,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [2:0]                      status,
	output logic                            verdict_kind,
	output logic [31:0]                     family_word,
	output logic [uf2v_pkg::CNT_W-1:0]      blocks_counted
);

	localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int unsigned XW = (AW > uf2v_pkg::CNT_W) ? AW : uf2v_pkg::CNT_W;
	localparam logic [16:0] MAX_L = 17'(MAX_BLOCKS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BLOCKS - 1);

	logic                       seen_mem [MAX_BLOCKS];
	logic                       rd_q;
	logic                       hit_q;

	logic                       clr_busy_q;
	logic [AW-1:0]              clr_addr_q;

	logic                       s1_vld_q;
	uf2v_pkg::job_t             job_s1;

	uf2v_pkg::status_t          sticky_q;
	logic [uf2v_pkg::CNT_W-1:0] total_q;
	logic                       known_q;
	logic [31:0]                det_fam_q;

	logic                       out_vld_q;
	uf2v_pkg::status_t          out_status_q;
	logic                       out_kind_q;
	logic [31:0]                out_fam_q;
	logic [uf2v_pkg::CNT_W-1:0] out_total_q;

	logic                       adv;
	logic [XW-1:0]              rd_x;
	logic [XW-1:0]              s1_x;
	logic [AW-1:0]              rd_addr;
	logic [AW-1:0]              s1_addr;
	logic                       seen;
	logic                       fam_ok;
	logic                       bad_block;
	logic                       mark;
	logic                       mem_we;
	logic [AW-1:0]              mem_wa;
	logic                       mem_wd;
	uf2v_pkg::status_t          st_nx;
	uf2v_pkg::status_t          sticky_nx;
	logic [uf2v_pkg::CNT_W-1:0] total_nx;
	logic                       known_nx;
	logic [31:0]                det_fam_nx;

	assign clearing = clr_busy_q;
	assign adv = s1_vld_q && (!out_vld_q || out_ready);
	assign pop = !empty && !clr_busy_q && (!s1_vld_q || adv);

	assign rd_x = XW'(head_job.idx_lo);
	assign s1_x = XW'(job_s1.idx_lo);
	assign rd_addr = rd_x[AW-1:0];
	assign s1_addr = s1_x[AW-1:0];
	assign seen = rd_q || hit_q;

	assign fam_ok = target_chip ?
		(job_s1.fam == uf2v_pkg::FAM_ALT0 || job_s1.fam == uf2v_pkg::FAM_ALT1 ||
		 job_s1.fam == uf2v_pkg::FAM_ALT2) :
		(job_s1.fam == uf2v_pkg::FAM_SINGLE);

	assign bad_block = job_s1.pay_big || job_s1.decl_big || job_s1.decl_lo != block_count ||
		job_s1.idx_big || job_s1.idx_lo >= block_count ||
		17'(job_s1.idx_lo) >= MAX_L;

	always_comb begin
		st_nx = uf2v_pkg::ST_OK;
		sticky_nx = sticky_q;
		total_nx = total_q;
		known_nx = known_q;
		det_fam_nx = det_fam_q;
		mark = 1'b0;
		if (job_s1.kind == uf2v_pkg::KIND_FINISH) begin
			if (sticky_q != uf2v_pkg::ST_OK) begin
				st_nx = sticky_q;
			end else if (!known_q) begin
				st_nx = uf2v_pkg::ST_NO_FAMILY;
			end else if (total_q != block_count) begin
				st_nx = uf2v_pkg::ST_INCOMPLETE;
			end
		end else if (sticky_q != uf2v_pkg::ST_OK) begin
			st_nx = sticky_q;
		end else if (job_s1.len_bad) begin
			st_nx = uf2v_pkg::ST_BAD_MAGIC;
			sticky_nx = st_nx;
		end else if (bad_block) begin
			st_nx = uf2v_pkg::ST_BAD_BLOCK;
			sticky_nx = st_nx;
		end else if (seen) begin
			st_nx = uf2v_pkg::ST_DUPLICATE;
			sticky_nx = st_nx;
		end else begin
			mark = 1'b1;
			if (total_q != uf2v_pkg::CNT_SAT) begin
				total_nx = total_q + 1'b1;
			end
			if (job_s1.fam_flag) begin
				if (!fam_ok) begin
					st_nx = uf2v_pkg::ST_WRONG_FAMILY;
					sticky_nx = st_nx;
				end else if (!known_q) begin
					known_nx = 1'b1;
					det_fam_nx = job_s1.fam;
				end
			end
		end
	end

	always_comb begin
		if (clr_busy_q) begin
			mem_we = 1'b1;
			mem_wa = clr_addr_q;
			mem_wd = 1'b0;
		end else begin
			mem_we = adv && mark;
			mem_wa = s1_addr;
			mem_wd = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			seen_mem[mem_wa] <= mem_wd;
		end
		if (pop) begin
			rd_q <= seen_mem[rd_addr];
			hit_q <= mem_we && (mem_wa == rd_addr);
		end
		if (pop) begin
			job_s1 <= head_job;
		end
		if (adv) begin
			out_status_q <= st_nx;
			out_kind_q <= job_s1.kind;
			out_fam_q <= det_fam_nx;
			out_total_q <= total_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			s1_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
			sticky_q <= uf2v_pkg::ST_OK;
			total_q <= '0;
			known_q <= 1'b0;
			det_fam_q <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == LAST_ADDR) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (pop) begin
				s1_vld_q <= 1'b1;
			end else if (adv) begin
				s1_vld_q <= 1'b0;
			end
			if (adv) begin
				out_vld_q <= 1'b1;
				sticky_q <= sticky_nx;
				total_q <= total_nx;
				known_q <= known_nx;
				det_fam_q <= det_fam_nx;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign status = out_status_q;
	assign verdict_kind = out_kind_q;
	assign family_word = out_fam_q;
	assign blocks_counted = out_total_q;

	a_sticky_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(sticky_q != uf2v_pkg::ST_OK) |=> (sticky_q == $past(sticky_q)))
		else $error("sticky status changed after an error");

	a_family_holds: assert property (@(posedge clk) disable iff (!arst_n)
		known_q |=> (known_q && $stable(det_fam_q)))
		else $error("detected family changed once known");

	a_no_pop_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !pop)
		else $error("job taken during bitmap clearing");

	a_mark_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && !clr_busy_q) |-> (adv && job_s1.kind == uf2v_pkg::KIND_BLOCK))
		else $error("bitmap written without a retiring block job");

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
`default_nettype none
module tb_top;
	import uf2v_pkg::*;

	localparam int MAX_BLOCKS = 8192;
	localparam int DRAIN_CYCLES = 4;
	localparam int GOOD_BLOCK_GOAL = 40;
	localparam logic [POS_W-1:0] BLOCK_LEN = 10'd512;
	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_FINISH = 1'b1;
	localparam logic [1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [1:0] CFG_SPARE_3 = 2'd3;

	typedef struct {
		status_t          st;
		logic             kind;
		logic [31:0]      fam;
		logic [CNT_W-1:0] cnt;
	} verdict_t;

	typedef struct {
		logic [31:0] idx;
		logic [31:0] decl;
		logic [31:0] pay;
		logic [31:0] flags;
		logic [31:0] fam;
		logic [31:0] magic_a;
		logic [31:0] magic_b;
		logic [31:0] magic_end;
		int          len;
	} uf2_hdr_t;

	typedef enum {ROW_CFG, ROW_FINISH, ROW_BLOCK, ROW_SPLIT} row_op_e;

	typedef struct {
		row_op_e          op;
		logic [1:0]       reg_idx;
		logic [CNT_W-1:0] val;
		logic [31:0]      idx;
		logic [31:0]      decl;
		logic [31:0]      pay;
		logic [31:0]      flags;
		logic [31:0]      fam;
		logic             typed;
		status_t          st;
		logic [31:0]      fam_w;
		logic [CNT_W-1:0] cnt;
	} row_t;

	typedef enum {
		F_SHORT, F_LONG, F_MAGIC_A, F_MAGIC_B, F_MAGIC_END, F_PAYLOAD,
		F_DECL, F_RANGE, F_BEYOND_MAP, F_DUP, F_FAMILY
	} fault_e;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [CNT_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic command;
	logic [7:0] data_byte;
	logic last_byte;
	logic out_valid;
	logic out_ready;
	logic [2:0] status;
	logic verdict_kind;
	logic [31:0] family_word;
	logic [CNT_W-1:0] blocks_counted;

	uf2_block_stream_validator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.verdict_kind(verdict_kind),
		.family_word(family_word),
		.blocks_counted(blocks_counted)
	);

	// Predictor state: per-block capture, then the file-wide bookkeeping.
	logic [CNT_W-1:0] cnt_cfg;
	logic chip_cfg;
	logic [POS_W-1:0] pos;
	logic [31:0] asm_w;
	bit magic_ok;
	bit fam_flag;
	logic [31:0] pay_len;
	logic [31:0] blk_idx;
	logic [31:0] decl_total;
	logic [31:0] fam_cand;
	bit seen [0:MAX_BLOCKS-1];
	int seen_list [$];
	logic [CNT_W-1:0] seen_cnt;
	status_t sticky;
	bit fam_known;
	logic [31:0] fam_det;

	verdict_t verdicts_due [$];
	bit use_typed;
	verdict_t typed_v;
	bit quiet;
	bit hold_req;
	int mismatches;
	int n_bytes;
	int n_finish;
	int n_verdicts;
	int good_blocks;
	fault_e fault;
	row_t script [0:17];

	function automatic void restart_capture();
		pos = '0;
		asm_w = '0;
		magic_ok = 1'b1;
		fam_flag = 1'b0;
		pay_len = '0;
		blk_idx = '0;
		decl_total = '0;
		fam_cand = '0;
	endfunction

	function automatic bit family_fits(logic [31:0] w);
		if (!chip_cfg)
			return w == FAM_SINGLE;
		return w == FAM_ALT0 || w == FAM_ALT1 || w == FAM_ALT2;
	endfunction

	function automatic void capture_byte(logic [7:0] b);
		if (pos < BLOCK_LEN) begin
			asm_w = {b, asm_w[31:8]};
			case (pos)
			POS_MAGIC_A: if (asm_w != MAGIC_A) magic_ok = 1'b0;
			POS_MAGIC_B: if (asm_w != MAGIC_B) magic_ok = 1'b0;
			POS_FLAGS: fam_flag = (asm_w & FLAG_FAMILY) != 0;
			POS_PAYLOAD: pay_len = asm_w;
			POS_INDEX: blk_idx = asm_w;
			POS_TOTAL: decl_total = asm_w;
			POS_FAMILY: fam_cand = asm_w;
			POS_BLOCK_END: if (asm_w != MAGIC_END) magic_ok = 1'b0;
			default: ;
			endcase
		end
		if (pos != POS_SAT)
			pos = pos + 1'b1;
	endfunction

	function automatic status_t judge_block();
		if (sticky != ST_OK)
			return sticky;
		if (pos != BLOCK_LEN || !magic_ok) begin
			sticky = ST_BAD_MAGIC;
			return sticky;
		end
		if (pay_len > PAYLOAD_MAX || decl_total != 32'(cnt_cfg) || blk_idx >= 32'(cnt_cfg)
				|| blk_idx >= MAX_BLOCKS) begin
			sticky = ST_BAD_BLOCK;
			return sticky;
		end
		if (seen[blk_idx[12:0]]) begin
			sticky = ST_DUPLICATE;
			return sticky;
		end
		seen[blk_idx[12:0]] = 1'b1;
		seen_list.push_back(int'(blk_idx));
		if (seen_cnt != CNT_SAT)
			seen_cnt = seen_cnt + 1'b1;
		if (fam_flag) begin
			if (!family_fits(fam_cand)) begin
				sticky = ST_WRONG_FAMILY;
				return sticky;
			end
			if (!fam_known) begin
				fam_det = fam_cand;
				fam_known = 1'b1;
			end
		end
		return ST_OK;
	endfunction

	function automatic bit predict_verdict(logic cmd, logic [7:0] b, logic lst, output verdict_t v);
		if (cmd == CMD_FINISH) begin
			if (sticky != ST_OK)
				v.st = sticky;
			else if (!fam_known)
				v.st = ST_NO_FAMILY;
			else
				v.st = (seen_cnt == cnt_cfg) ? ST_OK : ST_INCOMPLETE;
			v.kind = KIND_FINISH;
		end else begin
			capture_byte(b);
			if (!lst)
				return 1'b0;
			v.st = judge_block();
			restart_capture();
			v.kind = KIND_BLOCK;
		end
		v.fam = fam_det;
		v.cnt = seen_cnt;
		return 1'b1;
	endfunction

	function automatic logic [31:0] fresh_index();
		int lim;
		int cand;
		lim = (int'(cnt_cfg) < MAX_BLOCKS) ? int'(cnt_cfg) : MAX_BLOCKS;
		for (int t = 0; t < 32; t++) begin
			cand = ($urandom_range(0, 7) == 0) ? lim - 1 : int'($urandom_range(0, lim - 1));
			if (!seen[cand])
				return cand;
		end
		for (int i = 0; i < lim; i++)
			if (!seen[i])
				return i;
		return 0;
	endfunction

	function automatic uf2_hdr_t good_hdr(logic [31:0] idx);
		uf2_hdr_t h;
		h.idx = idx;
		h.decl = 32'(cnt_cfg);
		case ($urandom_range(0, 3))
		0: h.pay = 0;
		1: h.pay = PAYLOAD_MAX;
		default: h.pay = $urandom_range(0, PAYLOAD_MAX);
		endcase
		h.flags = $urandom;
		if ($urandom_range(0, 3) != 0)
			h.flags = h.flags | FLAG_FAMILY;
		else
			h.flags = h.flags & ~FLAG_FAMILY;
		if (!chip_cfg)
			h.fam = FAM_SINGLE;
		else
			case ($urandom_range(0, 2))
			0: h.fam = FAM_ALT0;
			1: h.fam = FAM_ALT1;
			default: h.fam = FAM_ALT2;
			endcase
		if ((h.flags & FLAG_FAMILY) == 0 && $urandom_range(0, 1) == 1)
			h.fam = $urandom;
		h.magic_a = MAGIC_A;
		h.magic_b = MAGIC_B;
		h.magic_end = MAGIC_END;
		h.len = 512;
		return h;
	endfunction

	task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= 100)
			$display("mismatch on %s at %0t: got %0h, expected %0h", what, $time, got, want);
	endtask

	task automatic push_item(logic cmd, logic [7:0] b, logic lst);
		verdict_t v;
		if (!quiet && $urandom_range(0, 15) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		data_byte <= b;
		last_byte <= lst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (predict_verdict(cmd, b, lst, v)) begin
			if (use_typed) begin
				v = typed_v;
				use_typed = 1'b0;
			end
			verdicts_due.push_back(v);
		end
		if (cmd == CMD_FINISH)
			n_finish++;
		else
			n_bytes++;
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (verdicts_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [CNT_W-1:0] val);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_BLOCK_COUNT)
			cnt_cfg = val;
		else if (idx == CFG_TARGET_CHIP)
			chip_cfg = val[0];
	endtask

	task automatic send_block(uf2_hdr_t h, int finish_odds);
		logic [7:0] img [0:511];
		for (int i = 0; i < 512; i++)
			img[i] = 8'($urandom);
		for (int k = 0; k < 4; k++) begin
			img[k] = 8'(h.magic_a >> (8 * k));
			img[4 + k] = 8'(h.magic_b >> (8 * k));
			img[8 + k] = 8'(h.flags >> (8 * k));
			img[16 + k] = 8'(h.pay >> (8 * k));
			img[20 + k] = 8'(h.idx >> (8 * k));
			img[24 + k] = 8'(h.decl >> (8 * k));
			img[28 + k] = 8'(h.fam >> (8 * k));
			img[508 + k] = 8'(h.magic_end >> (8 * k));
		end
		for (int i = 0; i < h.len; i++) begin
			if (finish_odds != 0 && $urandom_range(1, finish_odds) == 1)
				push_item(CMD_FINISH, 8'($urandom), 1'($urandom));
			push_item(CMD_DATA, (i < 512) ? img[i] : 8'($urandom), i == h.len - 1);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#60_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				stall_left = 400;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 15) == 0) begin
				stall_left = $urandom_range(0, 16);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			n_verdicts++;
			if (verdicts_due.size() == 0) begin
				note_mismatch("unexpected verdict, status", 32'(status), 0);
			end else begin
				want = verdicts_due.pop_front();
				if (status !== want.st)
					note_mismatch("status", 32'(status), 32'(want.st));
				if (verdict_kind !== want.kind)
					note_mismatch("verdict_kind", 32'(verdict_kind), 32'(want.kind));
				if (family_word !== want.fam)
					note_mismatch("family_word", family_word, want.fam);
				if (blocks_counted !== want.cnt)
					note_mismatch("blocks_counted", 32'(blocks_counted), 32'(want.cnt));
			end
		end
	end

	initial begin
		row_t row;
		uf2_hdr_t h;
		int k;
		int newcnt;
		int phase;
		int tries;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_BLOCK_COUNT;
		cfg_wdata = '0;
		in_valid = 1'b0;
		command = CMD_DATA;
		data_byte = '0;
		last_byte = 1'b0;
		quiet = 1'b0;
		hold_req = 1'b0;
		use_typed = 1'b0;
		mismatches = 0;
		n_bytes = 0;
		n_finish = 0;
		n_verdicts = 0;
		good_blocks = 0;
		fault = F_SHORT;
		cnt_cfg = '0;
		chip_cfg = 1'b0;
		restart_capture();
		foreach (seen[i])
			seen[i] = 1'b0;
		seen_cnt = '0;
		sticky = ST_OK;
		fam_known = 1'b0;
		fam_det = '0;

		// op, reg, value, index, declared, payload, flags, family, typed, status, family, count
		script = '{
			'{ROW_FINISH, CFG_BLOCK_COUNT, 14'd0, 0, 0, 0, 0, 0, 1'b1, ST_NO_FAMILY, 0, 14'd0},
			'{ROW_CFG, CFG_SPARE_2, 14'h3FFF, 0, 0, 0, 0, 0, 1'b0, ST_OK, 0, 14'd0},
			'{ROW_CFG, CFG_SPARE_3, 14'd5, 0, 0, 0, 0, 0, 1'b0, ST_OK, 0, 14'd0},
			'{ROW_CFG, CFG_BLOCK_COUNT, 14'd0, 0, 0, 0, 0, 0, 1'b0, ST_OK, 0, 14'd0},
			'{ROW_CFG, CFG_TARGET_CHIP, 14'd0, 0, 0, 0, 0, 0, 1'b0, ST_OK, 0, 14'd0},
			'{ROW_FINISH, CFG_BLOCK_COUNT, 14'd0, 0, 0, 0, 0, 0, 1'b1, ST_NO_FAMILY, 0, 14'd0},
			'{ROW_CFG, CFG_BLOCK_COUNT, 14'd8192, 0, 0, 0, 0, 0, 1'b0, ST_OK, 0, 14'd0},
			'{ROW_CFG, CFG_TARGET_CHIP, 14'd1, 0, 0, 0, 0, 0, 1'b0, ST_OK, 0, 14'd0},
			'{ROW_BLOCK, CFG_BLOCK_COUNT, 14'd0, 8191, 8192, PAYLOAD_MAX, FLAG_FAMILY, FAM_ALT2,
				1'b1, ST_OK, FAM_ALT2, 14'd1},
			'{ROW_BLOCK, CFG_BLOCK_COUNT, 14'd0, 0, 8192, 0, 32'hFFFF_DFFF, 0,
				1'b0, ST_OK, 0, 14'd0},
			'{ROW_FINISH, CFG_BLOCK_COUNT, 14'd0, 0, 0, 0, 0, 0, 1'b1, ST_INCOMPLETE, FAM_ALT2, 14'd2},
			'{ROW_SPLIT, CFG_BLOCK_COUNT, 14'd0, 1, 8192, 256, FLAG_FAMILY, FAM_ALT0,
				1'b0, ST_OK, 0, 14'd0},
			'{ROW_BLOCK, CFG_BLOCK_COUNT, 14'd0, 2, 8192, 100, FLAG_FAMILY | 32'd1, FAM_ALT1,
				1'b0, ST_OK, 0, 14'd0},
			'{ROW_CFG, CFG_TARGET_CHIP, 14'd0, 0, 0, 0, 0, 0, 1'b0, ST_OK, 0, 14'd0},
			'{ROW_CFG, CFG_BLOCK_COUNT, 14'd5, 0, 0, 0, 0, 0, 1'b0, ST_OK, 0, 14'd0},
			'{ROW_BLOCK, CFG_BLOCK_COUNT, 14'd0, 4, 5, 476, FLAG_FAMILY, FAM_SINGLE,
				1'b0, ST_OK, 0, 14'd0},
			'{ROW_FINISH, CFG_BLOCK_COUNT, 14'd0, 0, 0, 0, 0, 0, 1'b1, ST_OK, FAM_ALT2, 14'd5},
			'{ROW_BLOCK, CFG_BLOCK_COUNT, 14'd0, 3, 5, 12, 0, FAM_ALT0, 1'b0, ST_OK, 0, 14'd0}
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[r]) begin
			row = script[r];
			use_typed = row.typed;
			typed_v = '{row.st, (row.op == ROW_FINISH) ? KIND_FINISH : KIND_BLOCK,
				row.fam_w, row.cnt};
			case (row.op)
			ROW_CFG: write_reg(row.reg_idx, row.val);
			ROW_FINISH: push_item(CMD_FINISH, 8'($urandom), 1'($urandom));
			default: begin
				h = '{row.idx, row.decl, row.pay, row.flags, row.fam, MAGIC_A, MAGIC_B,
					MAGIC_END, 512};
				send_block(h, (row.op == ROW_SPLIT) ? 64 : 0);
			end
			endcase
		end

		phase = 0;
		while (good_blocks < GOOD_BLOCK_GOAL) begin
			k = $urandom_range(1, 4);
			case ($urandom_range(0, 3))
			0: newcnt = int'(seen_cnt) + k;
			1: newcnt = MAX_BLOCKS;
			default: newcnt = $urandom_range(int'(seen_cnt) + k, MAX_BLOCKS);
			endcase
			write_reg(CFG_BLOCK_COUNT, 14'(newcnt));
			write_reg(CFG_TARGET_CHIP, 14'($urandom_range(0, 1)));
			if (phase == 1) begin
				// The output side is held blocked while finish queries keep coming, so the job queue fills.
				hold_req = 1'b1;
				repeat (40) push_item(CMD_FINISH, 8'($urandom), 1'($urandom));
				settle();
			end
			repeat (k) begin
				send_block(good_hdr(fresh_index()), 200);
				good_blocks++;
				if ($urandom_range(0, 1) == 1)
					push_item(CMD_FINISH, 8'($urandom), 1'($urandom));
			end
			push_item(CMD_FINISH, 8'($urandom), 1'($urandom));
			phase++;
		end

		// One error is injected, and from then on every verdict must repeat it.
		settle();
		quiet = 1'b1;
		fault = fault_e'($urandom_range(0, int'(F_FAMILY)));
		write_reg(CFG_BLOCK_COUNT,
			(fault == F_BEYOND_MAP) ? 14'(MAX_BLOCKS) : 14'(int'(seen_cnt) + 4));
		h = good_hdr(fresh_index());
		case (fault)
		F_SHORT: h.len = $urandom_range(1, 511);
		F_LONG: h.len = ($urandom_range(0, 1) == 1) ? 513 : int'($urandom_range(1024, 1100));
		F_MAGIC_A: h.magic_a = h.magic_a ^ (32'd1 << $urandom_range(0, 31));
		F_MAGIC_B: h.magic_b = h.magic_b ^ (32'd1 << $urandom_range(0, 31));
		F_MAGIC_END: h.magic_end = h.magic_end ^ (32'd1 << $urandom_range(0, 31));
		F_PAYLOAD: h.pay = $urandom_range(477, 32'hFFFF_FFFF);
		F_DECL: h.decl = ($urandom_range(0, 1) == 1) ? 32'(cnt_cfg) + $urandom_range(1, 9) : 0;
		F_RANGE: h.idx = 32'(cnt_cfg) + $urandom_range(0, 50);
		F_BEYOND_MAP: h.idx = $urandom_range(MAX_BLOCKS, 32'hFFFF_FFFF);
		F_DUP: begin
			h.idx = 0;
			for (tries = 0; tries < 16; tries++) begin
				k = seen_list[$urandom_range(0, seen_list.size() - 1)];
				if (k < int'(cnt_cfg))
					h.idx = k;
			end
		end
		default: begin
			h.flags = h.flags | FLAG_FAMILY;
			if ($urandom_range(0, 1) == 1)
				h.fam = chip_cfg ? FAM_SINGLE : FAM_ALT0;
			else
				h.fam = $urandom;
		end
		endcase
		send_block(h, 0);
		send_block(good_hdr(fresh_index()), 0);
		push_item(CMD_FINISH, 8'($urandom), 1'($urandom));
		repeat (150)
			push_item(($urandom_range(0, 7) == 0) ? CMD_FINISH : CMD_DATA, 8'($urandom),
				$urandom_range(0, 15) == 0);
		push_item(CMD_DATA, 8'($urandom), 1'b1);
		push_item(CMD_FINISH, 8'($urandom), 1'($urandom));
		settle();

		$display("Run covered %0d data bytes and %0d finish queries, %0d verdicts checked.",
			n_bytes, n_finish, n_verdicts);
		$display("%0d distinct blocks were marked seen; the closing error case was %s.",
			seen_cnt, fault.name());
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire

FILE: filelist.f
hdl/uf2v_pkg.sv
hdl/uf2v_front.sv
hdl/uf2v_fifo.sv
hdl/uf2v_back.sv
hdl/uf2_block_stream_validator_top.sv
dv/tb_top.sv
